FILE: sv/lrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  // Field and state widths
  localparam int EPOCH_W   = 16;
  localparam int RATE_W    = 32;
  localparam int LOSS_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int FACTOR_W  = 31;
  localparam int MARGIN_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_RATE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COSINE_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_RATE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PATIENCE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMPROVE       = 3'd7;

  // Schedule modes
  localparam logic [1:0] MODE_STEP    = 2'd0;
  localparam logic [1:0] MODE_EXP     = 2'd1;
  localparam logic [1:0] MODE_COSINE  = 2'd2;
  localparam logic [1:0] MODE_PLATEAU = 2'd3;

  // Reset values
  localparam logic [RATE_W-1:0]   START_RATE_RST    = 32'd1073742;
  localparam logic [PERIOD_W-1:0] DECAY_PERIOD_RST  = 16'd30;
  localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST  = 31'd107374182;
  localparam logic [PERIOD_W-1:0] COSINE_PERIOD_RST = 16'd100;
  localparam logic [15:0]         PATIENCE_RST      = 16'd10;
  localparam logic [LOSS_W-1:0]   LOWEST_LOSS_RST   = 32'h7FFF_FFFF;

  // Fixed point
  localparam int Q_FRAC = 30;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Cosine table
  localparam int COS_LOG2  = 10;
  localparam int COS_N     = 1 << COS_LOG2;
  localparam int COS_IDX_W = COS_LOG2 + 1;

  // Taylor denominators (2j-1)(2j)
  localparam logic [63:0] TAYLOR_D1 = 64'd2;
  localparam logic [63:0] TAYLOR_D2 = 64'd12;
  localparam logic [63:0] TAYLOR_D3 = 64'd30;
  localparam logic [63:0] TAYLOR_D4 = 64'd56;
  localparam logic [63:0] TAYLOR_D5 = 64'd90;
  localparam logic [63:0] TAYLOR_D6 = 64'd132;
  localparam logic [63:0] TAYLOR_D7 = 64'd182;
  localparam logic [63:0] TAYLOR_D8 = 64'd240;

  // Shared divider
  localparam int DIV_W   = 48;
  localparam int DVS_W   = PERIOD_W + 1;
  localparam int STEPS_W = 6;

  typedef logic [RATE_W-1:0] cos_tab_t [0:COS_N];

  typedef struct packed {
    logic               start;
    logic [STEPS_W-1:0] steps;
    logic [DIV_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // Elaboration only: (1+cos(pi*k/N))/2 as c*c with c = cos(pi*k/(2N)), Q30
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] t;
    logic [63:0] cu;
    longint      c;
    for (int k = 0; k <= COS_N; k++) begin
      y  = (PI_Q30 * 64'(k)) >> (COS_LOG2 + 1);
      y2 = (y * y) >> Q_FRAC;
      t  = Q30_ONE;
      c  = longint'(Q30_ONE);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D1; c = c - longint'(t);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D2; c = c + longint'(t);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D3; c = c - longint'(t);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D4; c = c + longint'(t);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D5; c = c - longint'(t);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D6; c = c + longint'(t);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D7; c = c - longint'(t);
      t = ((t * y2) >> Q_FRAC) / TAYLOR_D8; c = c + longint'(t);
      if (c < 0) c = 0;
      if (c > longint'(Q30_ONE)) c = longint'(Q30_ONE);
      cu = 64'(c);
      tab[k] = RATE_W'((cu * cu) >> Q_FRAC);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lrs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lrs_loss_if;
  logic                             valid;
  logic                             ready;
  logic signed [lrs_pkg::LOSS_W-1:0] loss_metric;

  modport source (output valid, output loss_metric, input ready);
  modport sink   (input valid, input loss_metric, output ready);
endinterface

interface lrs_result_if;
  logic                         valid;
  logic                         ready;
  logic [lrs_pkg::RATE_W-1:0]   learning_rate;
  logic [lrs_pkg::EPOCH_W-1:0]  epoch_number;
  logic                         rate_reduced;

  modport source (output valid, output learning_rate, output epoch_number,
                  output rate_reduced, input ready);
  modport sink   (input valid, input learning_rate, input epoch_number,
                  input rate_reduced, output ready);
endinterface

`default_nettype wire

FILE: sv/lrs_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Dividend is top-aligned; the quotient sits in quot when done is raised.
module lrs_div (
  input  logic              clk,
  input  logic              rst,
  input  lrs_pkg::div_req_t req,
  output lrs_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [lrs_pkg::STEPS_W-1:0]       cnt;
  logic [lrs_pkg::DIV_W-1:0]         acc;
  logic [lrs_pkg::DVS_W-1:0]         r;
  logic [lrs_pkg::DVS_W-1:0]         dvs;
  logic [lrs_pkg::DVS_W:0]           trial;
  logic                              qbit;
  logic [lrs_pkg::DVS_W:0]           trial_sub;

  assign trial     = {r, acc[lrs_pkg::DIV_W-1]};
  assign qbit      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == lrs_pkg::STEPS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.dividend;
      r   <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      acc <= {acc[lrs_pkg::DIV_W-2:0], qbit};
      r   <= qbit ? trial_sub[lrs_pkg::DVS_W-1:0] : trial[lrs_pkg::DVS_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = acc;
  assign rsp.rem  = r;

endmodule

`default_nettype wire

FILE: sv/learning_rate_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat payload                                   Handshake
// loss      in   loss_metric (s32, Q16.16)                      valid/ready
// result    out  learning_rate (u32 Q2.30), epoch_number (u16),  valid/ready
//                rate_reduced (1)
// cfg       in   cfg_index (3), cfg_data (32)                   cfg_we, no wait
//
// No-multiply beats pass S_IDLE, S_EVAL and S_DONE; beats with one multiply
// (step/exp decay, plateau cut) add S_MULW and S_SCALE. Input reopens when the
// sequencer returns to S_IDLE. Cosine beats run the bit-serial divider three
// times (16 + 26 + 46 steps): phase modulo, table position and interpolation,
// plus ROM reads and multiplies. The 1025-entry table is a constant ROM.
// Sync reset clears all schedule state; a held result parks the sequencer.
module learning_rate_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrs_pkg::CFG_W-1:0]          cfg_data,
  lrs_loss_if.sink                           loss,
  lrs_result_if.source                       result
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;   // per-mode decision
  localparam logic [3:0] S_MULW  = 4'd2;   // product being formed
  localparam logic [3:0] S_SCALE = 4'd3;   // running_rate * factor
  localparam logic [3:0] S_CMOD  = 4'd4;   // e mod 2T
  localparam logic [3:0] S_CIDX  = 4'd5;   // p*N / T
  localparam logic [3:0] S_CRDA  = 4'd6;   // ROM read of lower entry
  localparam logic [3:0] S_CRDB  = 4'd7;   // ROM read of upper entry
  localparam logic [3:0] S_CDIFF = 4'd8;   // d * frac
  localparam logic [3:0] S_CDW   = 4'd9;
  localparam logic [3:0] S_CDD   = 4'd10;  // (d*frac) / T
  localparam logic [3:0] S_CW    = 4'd11;  // span * w
  localparam logic [3:0] S_CSW   = 4'd12;
  localparam logic [3:0] S_CSPAN = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  localparam lrs_pkg::cos_tab_t COS_TAB = lrs_pkg::build_cos_tab();

  // Configuration
  logic [1:0]                      mode;
  logic [lrs_pkg::RATE_W-1:0]      start_rate;
  logic [lrs_pkg::PERIOD_W-1:0]    decay_period;
  logic [lrs_pkg::FACTOR_W-1:0]    decay_factor;
  logic [lrs_pkg::PERIOD_W-1:0]    cosine_period;
  logic [lrs_pkg::RATE_W-1:0]      floor_rate;
  logic [15:0]                     patience;
  logic [lrs_pkg::MARGIN_W-1:0]    improve_margin;

  // Schedule state
  logic [3:0]                      state;
  logic [lrs_pkg::EPOCH_W-1:0]     epoch_count;
  logic [lrs_pkg::RATE_W-1:0]      running_rate;
  logic [lrs_pkg::PERIOD_W-1:0]    period_phase;
  logic [lrs_pkg::LOSS_W-1:0]      lowest_loss;
  logic [15:0]                     wait_count;
  logic [15:0]                     cooldown_count;
  logic                            advanced;
  logic                            reduced;
  logic [lrs_pkg::LOSS_W-1:0]      loss_q;
  logic [lrs_pkg::RATE_W-1:0]      rate_res;

  // Output register
  logic                            out_valid;
  logic [lrs_pkg::RATE_W-1:0]      out_rate;
  logic [lrs_pkg::EPOCH_W-1:0]     out_epoch;
  logic                            out_reduced;

  // Shared multiplier: registered operands, registered product
  logic [31:0]                     mul_a;
  logic [31:0]                     mul_b;
  logic [63:0]                     prod;

  // Shared divider
  lrs_pkg::div_req_t               div_req;
  lrs_pkg::div_rsp_t               div_rsp;
  logic                            div_start;
  logic [lrs_pkg::STEPS_W-1:0]     div_steps;
  logic [lrs_pkg::DIV_W-1:0]       div_dividend;
  logic [lrs_pkg::DVS_W-1:0]       div_divisor;

  // Cosine working registers
  logic [lrs_pkg::COS_IDX_W-1:0]   rom_addr;
  logic [lrs_pkg::RATE_W-1:0]      rom_q;
  logic [lrs_pkg::RATE_W-1:0]      cos_a;
  logic [lrs_pkg::PERIOD_W-1:0]    frac;

  // Combinational helpers
  logic [lrs_pkg::PERIOD_W-1:0]    step_per;
  logic [lrs_pkg::PERIOD_W-1:0]    phase_inc;
  logic [lrs_pkg::PERIOD_W-1:0]    cos_t;
  logic [lrs_pkg::DVS_W-1:0]       cos_2t;
  logic [lrs_pkg::DVS_W-1:0]       refl_p;
  logic [lrs_pkg::RATE_W-1:0]      cos_d;
  logic [lrs_pkg::RATE_W-1:0]      cos_w;
  logic                            rate_up;
  logic [lrs_pkg::RATE_W-1:0]      span;
  logic [63:0]                     prod_sh;
  logic [lrs_pkg::RATE_W-1:0]      scaled;
  logic signed [lrs_pkg::LOSS_W:0] thresh;
  logic signed [lrs_pkg::LOSS_W:0] loss_x;
  logic                            improve;
  logic [15:0]                     wait_inc;
  logic                            cut;
  logic [15:0]                     cd_base;
  logic                            out_free;

  assign step_per  = (decay_period == '0) ? lrs_pkg::PERIOD_W'(1) : decay_period;
  assign phase_inc = period_phase + 1'b1;
  assign cos_t     = (cosine_period == '0) ? lrs_pkg::PERIOD_W'(1) : cosine_period;
  assign cos_2t    = {cos_t, 1'b0};

  // Reflect the phase into the first half period
  assign refl_p = (div_rsp.rem > {1'b0, cos_t}) ? (cos_2t - div_rsp.rem) : div_rsp.rem;

  assign cos_d   = (cos_a > rom_q) ? (cos_a - rom_q) : '0;
  assign cos_w   = cos_a - lrs_pkg::RATE_W'(div_rsp.quot);
  assign rate_up = start_rate >= floor_rate;
  assign span    = rate_up ? (start_rate - floor_rate) : (floor_rate - start_rate);

  // Q30 product with saturation at 32 bits
  assign prod_sh = prod >> lrs_pkg::Q_FRAC;
  assign scaled  = (prod_sh[63:32] != '0) ? {lrs_pkg::RATE_W{1'b1}} : prod_sh[31:0];

  // Plateau decision
  assign loss_x   = $signed({loss_q[lrs_pkg::LOSS_W-1], loss_q});
  assign thresh   = $signed({lowest_loss[lrs_pkg::LOSS_W-1], lowest_loss})
                  - $signed({2'b00, improve_margin});
  assign improve  = loss_x < thresh;
  assign wait_inc = (wait_count != lrs_pkg::WAIT_MAX) ? (wait_count + 1'b1) : wait_count;
  assign cut      = !improve && (wait_inc >= patience) && (cooldown_count == '0);
  assign cd_base  = cut ? patience : cooldown_count;

  assign out_free = !out_valid || result.ready;

  assign div_req.start    = div_start;
  assign div_req.steps    = div_steps;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = div_divisor;

  lrs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration registers (running_rate load lives with the sequencer)
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lrs_pkg::MODE_STEP;
      start_rate     <= lrs_pkg::START_RATE_RST;
      decay_period   <= lrs_pkg::DECAY_PERIOD_RST;
      decay_factor   <= lrs_pkg::DECAY_FACTOR_RST;
      cosine_period  <= lrs_pkg::COSINE_PERIOD_RST;
      floor_rate     <= '0;
      patience       <= lrs_pkg::PATIENCE_RST;
      improve_margin <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lrs_pkg::REG_MODE:          mode           <= cfg_data[1:0];
        lrs_pkg::REG_START_RATE:    start_rate     <= cfg_data;
        lrs_pkg::REG_DECAY_PERIOD:  decay_period   <= cfg_data[lrs_pkg::PERIOD_W-1:0];
        lrs_pkg::REG_DECAY_FACTOR:  decay_factor   <= cfg_data[lrs_pkg::FACTOR_W-1:0];
        lrs_pkg::REG_COSINE_PERIOD: cosine_period  <= cfg_data[lrs_pkg::PERIOD_W-1:0];
        lrs_pkg::REG_FLOOR_RATE:    floor_rate     <= cfg_data;
        lrs_pkg::REG_PATIENCE:      patience       <= cfg_data[15:0];
        lrs_pkg::REG_IMPROVE:       improve_margin <= cfg_data[lrs_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Multiplier and cosine ROM
  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    rom_q <= COS_TAB[rom_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      epoch_count    <= '0;
      running_rate   <= lrs_pkg::START_RATE_RST;
      period_phase   <= '0;
      lowest_loss    <= lrs_pkg::LOWEST_LOSS_RST;
      wait_count     <= '0;
      cooldown_count <= '0;
      out_valid      <= 1'b0;
      div_start      <= 1'b0;
      advanced       <= 1'b0;
      reduced        <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && result.ready) out_valid <= 1'b0;
      if (cfg_we && cfg_index == lrs_pkg::REG_START_RATE) running_rate <= cfg_data;

      case (state)
        S_IDLE: begin
          if (loss.valid) begin
            loss_q   <= loss.loss_metric;
            reduced  <= 1'b0;
            advanced <= epoch_count != lrs_pkg::EPOCH_MAX;
            if (epoch_count != lrs_pkg::EPOCH_MAX) epoch_count <= epoch_count + 1'b1;
            state <= S_EVAL;
          end
        end

        S_EVAL: begin
          mul_a    <= running_rate;
          mul_b    <= {1'b0, decay_factor};
          rate_res <= running_rate;
          case (mode)
            lrs_pkg::MODE_STEP: begin
              if (advanced && phase_inc >= step_per) begin
                period_phase <= '0;
                state        <= S_MULW;
              end else begin
                if (advanced) period_phase <= phase_inc;
                state <= S_DONE;
              end
            end
            lrs_pkg::MODE_EXP: begin
              state <= advanced ? S_MULW : S_DONE;
            end
            lrs_pkg::MODE_COSINE: begin
              div_start    <= 1'b1;
              div_steps    <= lrs_pkg::STEPS_W'(lrs_pkg::EPOCH_W);
              div_dividend <= {epoch_count, {(lrs_pkg::DIV_W - lrs_pkg::EPOCH_W){1'b0}}};
              div_divisor  <= cos_2t;
              state        <= S_CMOD;
            end
            default: begin
              if (improve) begin
                lowest_loss <= loss_q;
                wait_count  <= '0;
              end else if (cut) begin
                wait_count <= '0;
              end else begin
                wait_count <= wait_inc;
              end
              reduced        <= cut;
              cooldown_count <= (cd_base != '0) ? (cd_base - 1'b1) : '0;
              state          <= cut ? S_MULW : S_DONE;
            end
          endcase
        end

        S_MULW: state <= S_SCALE;

        S_SCALE: begin
          running_rate <= scaled;
          rate_res     <= scaled;
          state        <= S_DONE;
        end

        S_CMOD: begin
          if (div_rsp.done) begin
            // num = p * N, 26 significant bits, top-aligned
            div_start    <= 1'b1;
            div_steps    <= lrs_pkg::STEPS_W'(lrs_pkg::PERIOD_W + lrs_pkg::COS_LOG2);
            div_dividend <= {refl_p[lrs_pkg::PERIOD_W-1:0],
                             {(lrs_pkg::DIV_W - lrs_pkg::PERIOD_W){1'b0}}};
            div_divisor  <= {1'b0, cos_t};
            state        <= S_CIDX;
          end
        end

        S_CIDX: begin
          if (div_rsp.done) begin
            rom_addr <= div_rsp.quot[lrs_pkg::COS_IDX_W-1:0];
            frac     <= div_rsp.rem[lrs_pkg::PERIOD_W-1:0];
            state    <= S_CRDA;
          end
        end

        S_CRDA: begin
          // last entry pairs with itself
          if (rom_addr != lrs_pkg::COS_IDX_W'(lrs_pkg::COS_N)) rom_addr <= rom_addr + 1'b1;
          state <= S_CRDB;
        end

        S_CRDB: begin
          cos_a <= rom_q;
          state <= S_CDIFF;
        end

        S_CDIFF: begin
          mul_a <= cos_d;
          mul_b <= {16'b0, frac};
          state <= S_CDW;
        end

        S_CDW: state <= S_CDD;

        S_CDD: begin
          div_start    <= 1'b1;
          div_steps    <= lrs_pkg::STEPS_W'(lrs_pkg::DIV_W - 2);
          div_dividend <= {prod[lrs_pkg::DIV_W-3:0], 2'b00};
          div_divisor  <= {1'b0, cos_t};
          state        <= S_CW;
        end

        S_CW: begin
          if (div_rsp.done) begin
            mul_a <= span;
            mul_b <= cos_w;
            state <= S_CSW;
          end
        end

        S_CSW: state <= S_CSPAN;

        S_CSPAN: begin
          // span * w never exceeds span, so no overflow here
          rate_res <= rate_up ? (floor_rate + prod_sh[31:0]) : (floor_rate - prod_sh[31:0]);
          state    <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_rate    <= rate_res;
            out_epoch   <= epoch_count;
            out_reduced <= reduced;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign loss.ready           = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.learning_rate = out_rate;
  assign result.epoch_number  = out_epoch;
  assign result.rate_reduced  = out_reduced;

endmodule

`default_nettype wire

FILE: sv/lrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lrs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lrs_pkg::RATE_W-1:0]   learning_rate,
  input logic [lrs_pkg::EPOCH_W-1:0]  epoch_number,
  input logic                         rate_reduced
);

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not empty and ready after reset");

  // One beat at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a beat while busy");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(learning_rate)
      && $stable(epoch_number) && $stable(rate_reduced))
    else $error("stalled result changed");

endmodule

bind learning_rate_scheduler lrs_checker u_lrs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (loss.valid),
  .in_ready      (loss.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .learning_rate (result.learning_rate),
  .epoch_number  (result.epoch_number),
  .rate_reduced  (result.rate_reduced)
);

`default_nettype wire

FILE: test/learning_rate_scheduler_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the learning-rate scheduler. Every accepted loss
// beat steps a local copy of the schedule and queues the expected result;
// each result beat is matched against the oldest queued one.
module learning_rate_scheduler_tb;

  localparam int unsigned LIMIT     = 2_000_000;  // cycle budget for the whole run
  localparam int          HOLD_LEN  = 400;        // long result-side hold-off
  localparam int          TAIL      = 150;        // covers the slow cosine path
  localparam int          SEG_BEATS = 25;
  localparam int          COS_STEPS = 1024;
  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [63:0] PI_FIX    = 64'd3373259426;
  localparam longint      LOSS_LO   = -64'sd2147483648;
  localparam longint      LOSS_HI   = 64'sd2147483647;

  typedef struct packed {
    logic [31:0] rate;
    logic [15:0] epoch;
    logic        cut;
  } sched_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lrs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lrs_pkg::CFG_W-1:0]     cfg_data;

  lrs_loss_if   loss_ch ();
  lrs_result_if res_ch ();

  learning_rate_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .loss      (loss_ch),
    .result    (res_ch)
  );

  // Schedule settings as last written
  logic [1:0]  sch_mode;
  logic [31:0] base_rate;
  logic [15:0] dec_per;
  logic [30:0] dec_fac;
  logic [15:0] cos_per;
  logic [31:0] min_rate;
  logic [15:0] pat;
  logic [30:0] margin;

  // Schedule state
  logic [15:0] epoch_cnt;
  logic [31:0] run_rate;
  logic [15:0] step_phase;
  longint      lowest_loss;
  logic [15:0] wait_cnt;
  logic [15:0] cool_cnt;

  // (1 + cos(pi*k/N)) / 2 in Q2.30
  logic [31:0] half_cos [0:COS_STEPS];

  sched_beat_t rate_due[$];
  sched_beat_t want;

  int          src_idle_pct;
  int          snk_idle_pct;
  int          hold_req;
  int          hold_seen;
  int          hold_left;
  int          mismatches;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Half-angle Taylor series through y^16, every term truncated, then squared.
  function automatic void fill_half_cos();
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] cu;
    longint      acc;
    for (int k = 0; k <= COS_STEPS; k++) begin
      y    = (PI_FIX * 64'(k)) / 64'(2 * COS_STEPS);
      y2   = (y * y) >> 30;
      term = 64'(ONE_Q30);
      acc  = longint'(ONE_Q30);
      for (int j = 1; j <= 8; j++) begin
        term = ((term * y2) >> 30) / 64'((2 * j - 1) * (2 * j));
        if (j % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      cu = 64'(acc);
      cu = (cu * cu) >> 30;
      half_cos[k] = cu[31:0];
    end
  endfunction

  function automatic void model_reset();
    sch_mode    = lrs_pkg::MODE_STEP;
    base_rate   = lrs_pkg::START_RATE_RST;
    dec_per     = lrs_pkg::DECAY_PERIOD_RST;
    dec_fac     = lrs_pkg::DECAY_FACTOR_RST;
    cos_per     = lrs_pkg::COSINE_PERIOD_RST;
    min_rate    = '0;
    pat         = lrs_pkg::PATIENCE_RST;
    margin      = '0;
    epoch_cnt   = '0;
    run_rate    = lrs_pkg::START_RATE_RST;
    step_phase  = '0;
    lowest_loss = LOSS_HI;
    wait_cnt    = '0;
    cool_cnt    = '0;
  endfunction

  function automatic void apply_cfg(logic [lrs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      lrs_pkg::REG_MODE:          sch_mode = data[1:0];
      lrs_pkg::REG_START_RATE: begin
        base_rate = data;
        run_rate  = data;   // a start-rate write reloads the running rate
      end
      lrs_pkg::REG_DECAY_PERIOD:  dec_per  = data[15:0];
      lrs_pkg::REG_DECAY_FACTOR:  dec_fac  = data[30:0];
      lrs_pkg::REG_COSINE_PERIOD: cos_per  = data[15:0];
      lrs_pkg::REG_FLOOR_RATE:    min_rate = data;
      lrs_pkg::REG_PATIENCE:      pat      = data[15:0];
      lrs_pkg::REG_IMPROVE:       margin   = data[30:0];
      default: ;
    endcase
  endfunction

  // Q2.30 product, truncated, saturating at all ones
  function automatic logic [31:0] scale_q30(logic [31:0] r, logic [30:0] f);
    logic [63:0] p;
    p = ({32'b0, r} * {33'b0, f}) >> 30;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [31:0] cosine_value(logic [15:0] e);
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [63:0] w;
    logic [63:0] span;
    t = (cos_per == 16'd0) ? 64'd1 : {48'b0, cos_per};
    p = {48'b0, e} % (t << 1);
    if (p > t) p = (t << 1) - p;   // rising half of the period
    num  = p * 64'(COS_STEPS);
    idx  = num / t;
    frac = num % t;
    if (idx > 64'(COS_STEPS)) idx = 64'(COS_STEPS);
    a = {32'b0, half_cos[idx]};
    b = (idx < 64'(COS_STEPS)) ? {32'b0, half_cos[idx + 1]} : a;
    d = (a > b) ? a - b : 64'd0;
    w = a - (d * frac) / t;
    if (base_rate >= min_rate) begin
      span = {32'b0, base_rate - min_rate};
      span = (span * w) >> 30;
      return min_rate + span[31:0];
    end
    // start below floor: climbs toward the floor
    span = {32'b0, min_rate - base_rate};
    span = (span * w) >> 30;
    return min_rate - span[31:0];
  endfunction

  // One end-of-epoch step; returns the result beat it should produce.
  function automatic sched_beat_t advance_schedule(logic [31:0] loss_bits);
    sched_beat_t o;
    logic        moved;
    logic [15:0] per;
    longint      loss;
    loss  = $signed(loss_bits);
    moved = (epoch_cnt != lrs_pkg::EPOCH_MAX);
    if (moved) epoch_cnt = epoch_cnt + 16'd1;
    o.cut = 1'b0;
    case (sch_mode)
      lrs_pkg::MODE_STEP: begin
        if (moved) begin
          per        = (dec_per == 16'd0) ? 16'd1 : dec_per;
          step_phase = step_phase + 16'd1;
          if (step_phase >= per) begin
            step_phase = '0;
            run_rate   = scale_q30(run_rate, dec_fac);
          end
        end
        o.rate = run_rate;
      end
      lrs_pkg::MODE_EXP: begin
        if (moved) run_rate = scale_q30(run_rate, dec_fac);
        o.rate = run_rate;
      end
      lrs_pkg::MODE_COSINE: o.rate = cosine_value(epoch_cnt);
      default: begin
        if (loss < lowest_loss - longint'(margin)) begin
          lowest_loss = loss;
          wait_cnt    = '0;
        end else begin
          if (wait_cnt != lrs_pkg::WAIT_MAX) wait_cnt = wait_cnt + 16'd1;
          if (wait_cnt >= pat && cool_cnt == 16'd0) begin
            run_rate = scale_q30(run_rate, dec_fac);
            wait_cnt = '0;
            cool_cnt = pat;
            o.cut    = 1'b1;
          end
        end
        if (cool_cnt != 16'd0) cool_cnt = cool_cnt - 16'd1;
        o.rate = run_rate;
      end
    endcase
    o.epoch = epoch_cnt;
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random ready, long hold-off on request, beat checker
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_LEN;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic void flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $time, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (rate_due.size() == 0) begin
        flag_mismatch("unexpected result beat", '0, res_ch.learning_rate);
      end else begin
        want = rate_due.pop_front();
        if (res_ch.learning_rate !== want.rate)
          flag_mismatch("learning_rate", want.rate, res_ch.learning_rate);
        if (res_ch.epoch_number !== want.epoch)
          flag_mismatch("epoch_number", 32'(want.epoch), 32'(res_ch.epoch_number));
        if (res_ch.rate_reduced !== want.cut)
          flag_mismatch("rate_reduced", 32'(want.cut), 32'(res_ch.rate_reduced));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Config writes only happen with nothing in flight.
  task automatic cfg_write(input logic [lrs_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one loss beat after a random gap; valid stays high for back-to-back.
  task automatic send_loss(input logic [31:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      loss_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    loss_ch.valid       <= 1'b1;
    loss_ch.loss_metric <= v;
    @(posedge clk);
    while (!loss_ch.ready) @(posedge clk);
    rate_due.push_back(advance_schedule(v));
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic await_results();
    loss_ch.valid <= 1'b0;
    @(posedge clk);
    while (rate_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] typical);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return typical;
  endfunction

  // Plateau traffic: mostly improving or stalling relative to the current
  // best, with a little full-range noise.
  function automatic logic [31:0] plateau_loss();
    longint      bar;
    longint      pick;
    int unsigned r;
    r   = $urandom_range(99);
    bar = lowest_loss - longint'(margin);
    if (r < 8) return $urandom;
    if (r < 50) begin
      pick = bar - 1 - longint'($urandom_range(4095));
      if (pick >= LOSS_LO) return pick[31:0];
    end
    pick = bar + longint'($urandom_range(65535));
    if (pick > LOSS_HI) pick = LOSS_HI;
    if (pick < LOSS_LO) pick = LOSS_LO;
    return pick[31:0];
  endfunction

  task automatic shuffle_settings();
    logic [31:0] f;
    cfg_write(lrs_pkg::REG_MODE, 32'($urandom_range(3)));
    if ($urandom_range(9) < 7)
      cfg_write(lrs_pkg::REG_START_RATE, pick_value(32'd0, 32'hFFFF_FFFF, $urandom));
    if ($urandom_range(1))
      cfg_write(lrs_pkg::REG_DECAY_PERIOD,
                pick_value(32'd0, 32'd65535, $urandom_range(1, 8)));
    if ($urandom_range(1)) begin
      f = pick_value(32'd0, ONE_Q30, $urandom_range(32'h3000_0000, ONE_Q30));
      if ($urandom_range(9) == 0) f = $urandom & 32'h7FFF_FFFF;  // any 31-bit factor, gain up to nearly two
      cfg_write(lrs_pkg::REG_DECAY_FACTOR, f);
    end
    if ($urandom_range(1))
      cfg_write(lrs_pkg::REG_COSINE_PERIOD,
                pick_value(32'd0, 32'd65535, $urandom_range(1, 40)));
    if ($urandom_range(1))
      cfg_write(lrs_pkg::REG_FLOOR_RATE, pick_value(32'd0, 32'hFFFF_FFFF, $urandom));
    if ($urandom_range(1))
      cfg_write(lrs_pkg::REG_PATIENCE, pick_value(32'd0, 32'd65535, $urandom_range(0, 6)));
    if ($urandom_range(1))
      cfg_write(lrs_pkg::REG_IMPROVE,
                pick_value(32'd0, 32'h7FFF_FFFF, $urandom_range(0, 32'h2_0000)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset values in step mode; loss is ignored here, so send its extremes.
  task automatic test_reset_state();
    send_loss(32'h7FFF_FFFF);
    send_loss(32'h8000_0000);
    send_loss(32'h0000_0000);
  endtask

  // Zero period acts as one, phase carries across a period change, factor zero.
  task automatic test_step_decay();
    await_results();
    cfg_write(lrs_pkg::REG_START_RATE, 32'hFFFF_FFFF);
    cfg_write(lrs_pkg::REG_DECAY_PERIOD, 32'd0);
    cfg_write(lrs_pkg::REG_DECAY_FACTOR, ONE_Q30 >> 1);
    send_loss($urandom);
    send_loss($urandom);
    await_results();
    cfg_write(lrs_pkg::REG_DECAY_PERIOD, 32'd65535);
    send_loss($urandom);
    await_results();
    cfg_write(lrs_pkg::REG_DECAY_FACTOR, 32'd0);
    cfg_write(lrs_pkg::REG_DECAY_PERIOD, 32'd1);
    send_loss($urandom);
  endtask

  // Gain above one saturates; unity gain; zero start rate.
  task automatic test_exponential();
    await_results();
    cfg_write(lrs_pkg::REG_MODE, 32'(lrs_pkg::MODE_EXP));
    cfg_write(lrs_pkg::REG_START_RATE, 32'hFFFF_FFFF);
    cfg_write(lrs_pkg::REG_DECAY_FACTOR, 32'h7FFF_FFFF);
    send_loss($urandom);
    send_loss($urandom);
    await_results();
    cfg_write(lrs_pkg::REG_DECAY_FACTOR, ONE_Q30);
    send_loss($urandom);
    await_results();
    cfg_write(lrs_pkg::REG_START_RATE, 32'd0);
    send_loss($urandom);
  endtask

  // Zero period, short period with interpolation, start below floor, long period.
  task automatic test_cosine();
    await_results();
    cfg_write(lrs_pkg::REG_MODE, 32'(lrs_pkg::MODE_COSINE));
    cfg_write(lrs_pkg::REG_START_RATE, ONE_Q30);
    cfg_write(lrs_pkg::REG_FLOOR_RATE, 32'd0);
    cfg_write(lrs_pkg::REG_COSINE_PERIOD, 32'd0);
    send_loss($urandom);
    send_loss($urandom);
    await_results();
    cfg_write(lrs_pkg::REG_COSINE_PERIOD, 32'd3);
    send_loss($urandom);
    send_loss($urandom);
    await_results();
    cfg_write(lrs_pkg::REG_START_RATE, 32'd0);
    cfg_write(lrs_pkg::REG_FLOOR_RATE, 32'hFFFF_FFFF);
    send_loss($urandom);
    await_results();
    cfg_write(lrs_pkg::REG_COSINE_PERIOD, 32'd65535);
    send_loss($urandom);
  endtask

  // Improve, stall up to patience, cut with cooldown, loss right on the
  // margin boundary; then patience zero with the widest margin.
  task automatic test_plateau();
    await_results();
    cfg_write(lrs_pkg::REG_MODE, 32'(lrs_pkg::MODE_PLATEAU));
    cfg_write(lrs_pkg::REG_START_RATE, ONE_Q30);
    cfg_write(lrs_pkg::REG_DECAY_FACTOR, ONE_Q30 >> 1);
    cfg_write(lrs_pkg::REG_PATIENCE, 32'd2);
    cfg_write(lrs_pkg::REG_IMPROVE, 32'h0001_0000);
    send_loss(32'h000A_0000);
    send_loss(32'h0009_8000);
    send_loss(32'h0009_0000);
    send_loss(32'h0009_0000);
    send_loss(32'h0005_0000);
    await_results();
    cfg_write(lrs_pkg::REG_PATIENCE, 32'd0);
    cfg_write(lrs_pkg::REG_IMPROVE, 32'h7FFF_FFFF);
    send_loss(32'h0000_0000);
    send_loss(32'h0001_0000);
  endtask

  // Result side held off for a long stretch while loss beats keep coming,
  // so the block fills and stalls its input; then a full drain.
  task automatic test_output_backpressure();
    int keep_pct;
    await_results();
    cfg_write(lrs_pkg::REG_MODE, 32'(lrs_pkg::MODE_STEP));
    cfg_write(lrs_pkg::REG_DECAY_PERIOD, 32'd3);
    keep_pct     = src_idle_pct;
    src_idle_pct = 0;
    hold_req    <= hold_req + 1;
    repeat (12) send_loss($urandom);
    src_idle_pct = keep_pct;
    await_results();
  endtask

  task automatic test_random_traffic(input int segments);
    for (int s = 0; s < segments; s++) begin
      await_results();
      shuffle_settings();
      for (int i = 0; i < SEG_BEATS; i++)
        send_loss((sch_mode == lrs_pkg::MODE_PLATEAU) ? plateau_loss() : $urandom);
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    fill_half_cos();
    model_reset();
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    loss_ch.valid       = 1'b0;
    loss_ch.loss_metric = '0;
    res_ch.ready        = 1'b0;
    hold_req            = 0;
    hold_seen           = 0;
    hold_left           = 0;
    mismatches          = 0;
    cycles              = 0;
    src_idle_pct        = 20;
    snk_idle_pct        = 46;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_step_decay();
    test_exponential();
    test_cosine();
    test_plateau();
    test_output_backpressure();
    test_random_traffic(10);

    // swap which side idles more
    src_idle_pct  = 46;
    snk_idle_pct <= 20;
    test_random_traffic(10);

    // full rate on both sides
    src_idle_pct  = 0;
    snk_idle_pct <= 0;
    test_random_traffic(10);

    await_results();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && rate_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
